>>> rtl/core/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg: shared types and constants for the HSV to RGB converter
// Holds fixed-point constants, the hue sector codes and pipeline structs.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int HUE_W  = 15;
  localparam int Q16_W  = 17;
  localparam int REM_W  = 12;
  localparam int K_W    = 28;
  localparam int PROD_W = Q16_W + K_W;
  localparam int CHAN_W = 8;

  localparam logic [HUE_W-1:0] HUE_FULL_TURN = 15'd23040;
  localparam logic [REM_W-1:0] HUE_SECTOR    = 12'd3840;
  localparam logic [Q16_W-1:0] Q16_ONE       = 17'd65536;
  // 1.0 times one sector in the (1 - s*x/3840) numerator
  localparam logic [K_W-1:0]   K_FULL        = 28'd251658240;

  typedef enum logic [2:0] {
    SECT_R_Y = 3'd0,
    SECT_Y_G = 3'd1,
    SECT_G_C = 3'd2,
    SECT_C_B = 3'd3,
    SECT_B_M = 3'd4,
    SECT_M_R = 3'd5
  } sector_t;

  typedef struct packed {
    logic             valid;
    sector_t          sector;
    logic [REM_W-1:0] rem;
    logic [Q16_W-1:0] sat;
    logic [Q16_W-1:0] bri;
  } dec_t;

  typedef struct packed {
    logic k;
    logic m;
  } term_en_t;

endpackage

>>> rtl/core/hsv2rgb_ifs.sv
// ----------------------------------------------------------------------------
// hsv2rgb_ifs: stream channels of the HSV to RGB converter
// Valid/ready channels for the HSV input and the RGB result.
// ----------------------------------------------------------------------------
interface hsv_if;
  logic        valid;
  logic        ready;
  logic [14:0] hue;
  logic [16:0] saturation;
  logic [16:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

>>> rtl/core/hsv2rgb_decode.sv
// ----------------------------------------------------------------------------
// hsv2rgb_decode: first pipeline stage
// Wraps the hue, splits it into sector and remainder, clamps s and v.
// ----------------------------------------------------------------------------
module hsv2rgb_decode (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 advance,
  input  logic                                 valid,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]        hue,
  input  logic [hsv2rgb_pkg::Q16_W-1:0]        saturation,
  input  logic [hsv2rgb_pkg::Q16_W-1:0]        brightness,
  output hsv2rgb_pkg::dec_t                    dec
);

  logic [hsv2rgb_pkg::HUE_W-1:0] hue_w;
  logic [hsv2rgb_pkg::HUE_W-1:0] base;
  hsv2rgb_pkg::sector_t          sector_next;
  logic [hsv2rgb_pkg::REM_W-1:0] rem_next;
  logic [hsv2rgb_pkg::Q16_W-1:0] sat_next;
  logic [hsv2rgb_pkg::Q16_W-1:0] bri_next;

  always_comb begin
    hue_w = (hue >= hsv2rgb_pkg::HUE_FULL_TURN) ? '0 : hue;
    if (hue_w < 15'd3840) begin
      sector_next = hsv2rgb_pkg::SECT_R_Y;
      base        = 15'd0;
    end else if (hue_w < 15'd7680) begin
      sector_next = hsv2rgb_pkg::SECT_Y_G;
      base        = 15'd3840;
    end else if (hue_w < 15'd11520) begin
      sector_next = hsv2rgb_pkg::SECT_G_C;
      base        = 15'd7680;
    end else if (hue_w < 15'd15360) begin
      sector_next = hsv2rgb_pkg::SECT_C_B;
      base        = 15'd11520;
    end else if (hue_w < 15'd19200) begin
      sector_next = hsv2rgb_pkg::SECT_B_M;
      base        = 15'd15360;
    end else begin
      sector_next = hsv2rgb_pkg::SECT_M_R;
      base        = 15'd19200;
    end
    rem_next = hsv2rgb_pkg::REM_W'(hue_w - base);
    // clamp Q16 inputs to 1.0
    sat_next = (saturation > hsv2rgb_pkg::Q16_ONE) ? hsv2rgb_pkg::Q16_ONE : saturation;
    bri_next = (brightness > hsv2rgb_pkg::Q16_ONE) ? hsv2rgb_pkg::Q16_ONE : brightness;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec.valid <= 1'b0;
    end else if (advance) begin
      dec.valid <= valid;
    end
    if (advance && valid) begin
      dec.sector <= sector_next;
      dec.rem    <= rem_next;
      dec.sat    <= sat_next;
      dec.bri    <= bri_next;
    end
  end

endmodule

>>> rtl/core/hsv2rgb_term.sv
// ----------------------------------------------------------------------------
// hsv2rgb_term: one product term v(1 - s*x/3840) scaled to 8 bits
// Two register stages: s*x numerator, then v times numerator.
// ----------------------------------------------------------------------------
module hsv2rgb_term (
  input  logic                                  clk,
  input  hsv2rgb_pkg::term_en_t                 en,
  input  logic [hsv2rgb_pkg::Q16_W-1:0]         sat,
  input  logic [hsv2rgb_pkg::REM_W-1:0]         x,
  input  logic [hsv2rgb_pkg::Q16_W-1:0]         bri,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]        chan
);

  localparam int Y_W = hsv2rgb_pkg::Q16_W + hsv2rgb_pkg::REM_W;
  localparam int T_W = hsv2rgb_pkg::PROD_W + 4;

  logic [Y_W-1:0]                  y;
  logic [hsv2rgb_pkg::K_W-1:0]     k;
  logic [hsv2rgb_pkg::PROD_W-1:0]  m;
  logic [T_W-1:0]                  t;

  assign y = Y_W'(sat) * Y_W'(x);

  always_ff @(posedge clk) begin
    if (en.k) begin
      k <= hsv2rgb_pkg::K_W'(Y_W'(hsv2rgb_pkg::K_FULL) - y);
    end
  end

  always_ff @(posedge clk) begin
    if (en.m) begin
      m <= hsv2rgb_pkg::PROD_W'(bri) * hsv2rgb_pkg::PROD_W'(k);
    end
  end

  // 255/(3840*2^32) reduces to 17/2^40
  assign t    = {m, 4'b0000} + T_W'(m);
  assign chan = t[47:40];

endmodule

>>> rtl/core/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter: streaming HSV to 8-bit RGB color conversion
// Four-stage pipeline, one pixel per clock unless the sink stalls, exact fixed-point arithmetic.
// ----------------------------------------------------------------------------
// The converter takes one pixel per clock on the hsv channel and delivers one
// pixel per clock on the rgb channel while the sink is ready. A transfer at
// the input passes through decode, numerator multiply (s times hue offset),
// brightness multiply, then scale and sector select into the output register.
// The brightness multiply (17 x 28 bits) sets the pace of the clock. Every
// stage has its own valid bit and advances when it is empty or the next
// stage advances, so bubbles close up and the input keeps taking pixels while
// any stage is empty, even while a result waits for the sink. Hue is in 1/64
// degree units and wraps to zero at 360 degrees; saturation and brightness
// above 1.0 are clamped. Each channel is truncated toward zero, exactly.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
  input  logic      clk,
  input  logic      rst,
  hsv_if.sink       hsv,
  rgb_if.source     rgb
);

  hsv2rgb_pkg::dec_t     dec;
  hsv2rgb_pkg::term_en_t term_en;

  logic en_d;
  logic en_k;
  logic en_m;
  logic en_o;

  // stage K and M control, stage O output registers
  logic                                 valid_k;
  logic                                 valid_m;
  logic                                 valid_o;
  hsv2rgb_pkg::sector_t                 sector_k;
  hsv2rgb_pkg::sector_t                 sector_m;
  logic [hsv2rgb_pkg::Q16_W-1:0]        bri_k;
  logic [hsv2rgb_pkg::REM_W-1:0]        x_c;
  logic [hsv2rgb_pkg::CHAN_W-1:0]       pv;
  logic [hsv2rgb_pkg::CHAN_W-1:0]       pa;
  logic [hsv2rgb_pkg::CHAN_W-1:0]       pb;
  logic [hsv2rgb_pkg::CHAN_W-1:0]       pc;
  logic [hsv2rgb_pkg::CHAN_W-1:0]       red;
  logic [hsv2rgb_pkg::CHAN_W-1:0]       green;
  logic [hsv2rgb_pkg::CHAN_W-1:0]       blue;
  logic [hsv2rgb_pkg::CHAN_W-1:0]       red_next;
  logic [hsv2rgb_pkg::CHAN_W-1:0]       green_next;
  logic [hsv2rgb_pkg::CHAN_W-1:0]       blue_next;

  // advance a stage when it is empty or the next one advances
  assign en_o = !valid_o || rgb.ready;
  assign en_m = !valid_m || en_o;
  assign en_k = !valid_k || en_m;
  assign en_d = !dec.valid || en_k;

  assign hsv.ready = en_d;
  assign term_en   = '{k: en_k, m: en_m};

  hsv2rgb_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .advance    (en_d),
    .valid      (hsv.valid),
    .hue        (hsv.hue),
    .saturation (hsv.saturation),
    .brightness (hsv.brightness),
    .dec        (dec)
  );

  // offset for v(1 - s(1-f))
  assign x_c = hsv2rgb_pkg::HUE_SECTOR - dec.rem;

  // pure brightness term: x of zero
  hsv2rgb_term u_term_v (
    .clk (clk), .en (term_en), .sat (dec.sat), .x ('0),
    .bri (bri_k), .chan (pv)
  );

  // v(1 - s)
  hsv2rgb_term u_term_a (
    .clk (clk), .en (term_en), .sat (dec.sat), .x (hsv2rgb_pkg::HUE_SECTOR),
    .bri (bri_k), .chan (pa)
  );

  // v(1 - s*f)
  hsv2rgb_term u_term_b (
    .clk (clk), .en (term_en), .sat (dec.sat), .x (dec.rem),
    .bri (bri_k), .chan (pb)
  );

  // v(1 - s*(1-f))
  hsv2rgb_term u_term_c (
    .clk (clk), .en (term_en), .sat (dec.sat), .x (x_c),
    .bri (bri_k), .chan (pc)
  );

  // valid bits travel alongside the term pipelines
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_k <= 1'b0;
      valid_m <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      if (en_k) begin
        valid_k <= dec.valid;
      end
      if (en_m) begin
        valid_m <= valid_k;
      end
      if (en_o) begin
        valid_o <= valid_m;
      end
    end
  end

  // hold the sector and brightness next to the terms
  always_ff @(posedge clk) begin
    if (en_k) begin
      sector_k <= dec.sector;
      bri_k    <= dec.bri;
    end
    if (en_m) begin
      sector_m <= sector_k;
    end
  end

  // pick the terms for each channel by hue sector
  always_comb begin
    case (sector_m)
      hsv2rgb_pkg::SECT_R_Y: begin
        red_next = pv; green_next = pc; blue_next = pa;
      end
      hsv2rgb_pkg::SECT_Y_G: begin
        red_next = pb; green_next = pv; blue_next = pa;
      end
      hsv2rgb_pkg::SECT_G_C: begin
        red_next = pa; green_next = pv; blue_next = pc;
      end
      hsv2rgb_pkg::SECT_C_B: begin
        red_next = pa; green_next = pb; blue_next = pv;
      end
      hsv2rgb_pkg::SECT_B_M: begin
        red_next = pc; green_next = pa; blue_next = pv;
      end
      default: begin
        red_next = pv; green_next = pa; blue_next = pb;
      end
    endcase
  end

  // output register: load on advance, hold while the sink stalls
  always_ff @(posedge clk) begin
    if (en_o) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

  assign rgb.valid = valid_o;
  assign rgb.red   = red;
  assign rgb.green = green;
  assign rgb.blue  = blue;

endmodule

>>> rtl/core/hsv2rgb_checker.sv
// ----------------------------------------------------------------------------
// hsv2rgb_checker: port-level checks for the HSV to RGB converter
// Flow control and latency checks, bound to the top level.
// ----------------------------------------------------------------------------
module hsv2rgb_checker (
  input  logic  clk,
  input  logic  rst,
  hsv_if.sink   hsv,
  rgb_if.source rgb
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !rgb.valid)
    else $error("result valid right after reset");

  // a held result keeps its payload while the sink stalls
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    rgb.valid && !rgb.ready |=> rgb.valid && $stable(rgb.red) &&
      $stable(rgb.green) && $stable(rgb.blue))
    else $error("stalled result changed");

  // an empty or draining output stage never blocks the input
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    !rgb.valid || rgb.ready |-> hsv.ready)
    else $error("input blocked while output can move");

  // with no stall, a transfer reaches the output through the decode, K, M and output registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (hsv.valid && hsv.ready) ##1 rgb.ready ##1 rgb.ready ##1 rgb.ready
      |=> rgb.valid)
    else $error("pixel did not arrive on time");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (
  .clk (clk),
  .rst (rst),
  .hsv (hsv),
  .rgb (rgb)
);

>>> dv/tb_hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter: self-checking bench for the HSV to RGB converter
// Streams directed and random HSV pixels through the hsv channel and predicts
// every RGB pixel in exact fixed point. Each RGB transfer is checked in order.
// Both channels idle at random. The sink is held off long enough to back up
// the pipeline, and the source waits out a full drain of the pipeline.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_converter;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_BLOCKS = 13;   // the last block runs with no idling
  localparam int BLOCK_LEN   = 125;
  localparam int LONG_HOLD   = 48;   // sink hold-off, well past pipeline depth
  localparam int TAIL_CYCLES = 16;

  // One pixel waiting to go out, with the idling it runs under.
  typedef struct {
    logic [hsv2rgb_pkg::HUE_W-1:0] hue;
    logic [hsv2rgb_pkg::Q16_W-1:0] sat;
    logic [hsv2rgb_pkg::Q16_W-1:0] bri;
    int unsigned      src_pct;      // chance in percent that the source idles
    int unsigned      snk_pct;      // sink idling chance from this pixel on
    bit               drain_first;  // hold back until no pixel is in flight
    bit               stall_sink;   // start a long sink hold-off
  } hsv_job_t;

  typedef struct packed {
    logic [hsv2rgb_pkg::CHAN_W-1:0] red;
    logic [hsv2rgb_pkg::CHAN_W-1:0] green;
    logic [hsv2rgb_pkg::CHAN_W-1:0] blue;
  } rgb_px_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Source and sink drive, all known from time zero.
  logic                          in_valid  = 1'b0;
  logic [hsv2rgb_pkg::HUE_W-1:0] in_hue    = '0;
  logic [hsv2rgb_pkg::Q16_W-1:0] in_sat    = '0;
  logic [hsv2rgb_pkg::Q16_W-1:0] in_bri    = '0;
  logic                          out_ready = 1'b0;

  hsv_job_t    pixels_to_send[$];
  rgb_px_t     rgb_due[$];
  int          n_items    = 0;
  int          n_taken    = 0;
  int          errors     = 0;
  bit          in_taken   = 1'b0;
  int unsigned snk_pct    = 0;
  int unsigned stall_reqs = 0;
  int unsigned stall_seen = 0;
  int          src_gap    = 0;
  int          snk_hold   = 0;

  hsv_if hsv_ch ();
  rgb_if rgb_ch ();

  assign hsv_ch.valid      = in_valid;
  assign hsv_ch.hue        = in_hue;
  assign hsv_ch.saturation = in_sat;
  assign hsv_ch.brightness = in_bri;
  assign rgb_ch.ready      = out_ready;

  hsv_to_rgb_converter uut (
    .clk (clk),
    .rst (rst),
    .hsv (hsv_ch),
    .rgb (rgb_ch)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // floor(255 * v * (1 - s*x/3840)), all in 64-bit integers so the only
  // rounding is the final truncation.
  function automatic logic [hsv2rgb_pkg::CHAN_W-1:0] scale_channel(
      input logic [hsv2rgb_pkg::Q16_W-1:0] v,
      input logic [hsv2rgb_pkg::Q16_W-1:0] s,
      input logic [hsv2rgb_pkg::REM_W-1:0] x);
    logic [63:0] k;
    logic [63:0] num;
    k   = 64'(hsv2rgb_pkg::Q16_ONE) * 64'(hsv2rgb_pkg::HUE_SECTOR) - 64'(s) * 64'(x);
    num = 64'd255 * 64'(v) * k;
    return hsv2rgb_pkg::CHAN_W'(num / (64'(hsv2rgb_pkg::HUE_SECTOR) << 32));
  endfunction

  function automatic rgb_px_t hsv_to_rgb_px(input logic [hsv2rgb_pkg::HUE_W-1:0] hue,
                                            input logic [hsv2rgb_pkg::Q16_W-1:0] sat,
                                            input logic [hsv2rgb_pkg::Q16_W-1:0] bri);
    int                             hh;
    logic [hsv2rgb_pkg::Q16_W-1:0]  s;
    logic [hsv2rgb_pkg::Q16_W-1:0]  v;
    logic [hsv2rgb_pkg::REM_W-1:0]  rem;
    hsv2rgb_pkg::sector_t           sec;
    logic [hsv2rgb_pkg::CHAN_W-1:0] pv, pa, pb, pc;
    rgb_px_t                        px;
    // Clamp to 1.0 and wrap a full turn of hue back to zero.
    s   = (sat > hsv2rgb_pkg::Q16_ONE) ? hsv2rgb_pkg::Q16_ONE : sat;
    v   = (bri > hsv2rgb_pkg::Q16_ONE) ? hsv2rgb_pkg::Q16_ONE : bri;
    hh  = (hue >= hsv2rgb_pkg::HUE_FULL_TURN) ? 0 : int'(hue);
    sec = hsv2rgb_pkg::sector_t'(3'(hh / int'(hsv2rgb_pkg::HUE_SECTOR)));
    rem = hsv2rgb_pkg::REM_W'(hh % int'(hsv2rgb_pkg::HUE_SECTOR));
    pv  = scale_channel(v, s, '0);
    pa  = scale_channel(v, s, hsv2rgb_pkg::HUE_SECTOR);
    pb  = scale_channel(v, s, rem);
    pc  = scale_channel(v, s, hsv2rgb_pkg::HUE_SECTOR - rem);
    case (sec)
      hsv2rgb_pkg::SECT_R_Y: px = '{red: pv, green: pc, blue: pa};
      hsv2rgb_pkg::SECT_Y_G: px = '{red: pb, green: pv, blue: pa};
      hsv2rgb_pkg::SECT_G_C: px = '{red: pa, green: pv, blue: pc};
      hsv2rgb_pkg::SECT_C_B: px = '{red: pa, green: pb, blue: pv};
      hsv2rgb_pkg::SECT_B_M: px = '{red: pc, green: pa, blue: pv};
      default:               px = '{red: pv, green: pa, blue: pb};
    endcase
    return px;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic void add_pixel(input int hue, input int sat, input int bri,
                                    input int unsigned src_pct,
                                    input int unsigned snk_pct_i,
                                    input bit drain_first = 1'b0,
                                    input bit stall_sink = 1'b0);
    hsv_job_t job;
    job.hue         = hsv2rgb_pkg::HUE_W'(hue);
    job.sat         = hsv2rgb_pkg::Q16_W'(sat);
    job.bri         = hsv2rgb_pkg::Q16_W'(bri);
    job.src_pct     = src_pct;
    job.snk_pct     = snk_pct_i;
    job.drain_first = drain_first;
    job.stall_sink  = stall_sink;
    pixels_to_send.push_back(job);
  endfunction

  // Mostly legal Q16 values, with the end points and the clamped range mixed in.
  function automatic int rand_q16();
    int sel;
    sel = $urandom_range(9, 0);
    case (sel)
      0:       return 0;
      1:       return int'(hsv2rgb_pkg::Q16_ONE);
      2:       return int'($urandom_range(131071, 0));
      default: return int'($urandom_range(65536, 0));
    endcase
  endfunction

  function automatic int rand_hue();
    // Keep most hues inside the turn; the rest cover the wrap region and all bits.
    if ($urandom_range(99, 0) < 80)
      return int'($urandom_range(23039, 0));
    return int'($urandom_range(32767, 0));
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic log_mismatch(input string what, input int got, input int want);
    errors++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Monitor: sample both channels at the rising edge. Predict each accepted
  // HSV pixel and compare each accepted RGB pixel against the oldest prediction.
  always @(posedge clk) begin
    rgb_px_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= hsv_ch.valid && hsv_ch.ready;
      if (hsv_ch.valid && hsv_ch.ready) begin
        rgb_due.push_back(hsv_to_rgb_px(hsv_ch.hue, hsv_ch.saturation, hsv_ch.brightness));
        n_taken++;
      end
      if (rgb_ch.valid && rgb_ch.ready) begin
        if (rgb_due.size() == 0) begin
          log_mismatch("unexpected rgb transfer", 1, 0);
        end else begin
          want = rgb_due.pop_front();
          if (rgb_ch.red !== want.red)
            log_mismatch("red", int'(rgb_ch.red), int'(want.red));
          if (rgb_ch.green !== want.green)
            log_mismatch("green", int'(rgb_ch.green), int'(want.green));
          if (rgb_ch.blue !== want.blue)
            log_mismatch("blue", int'(rgb_ch.blue), int'(want.blue));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Source driver: change inputs at the falling edge. A held pixel keeps valid
  // high until its transfer; only a free slot may idle or load the next pixel.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    hsv_job_t job;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (pixels_to_send.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pixels_to_send[0].drain_first && rgb_due.size() != 0) begin
        // Pause until every pixel in flight has come out.
        in_valid <= 1'b0;
      end else if ($urandom_range(99, 0) < pixels_to_send[0].src_pct) begin
        // Start an idle burst with this cycle; src_gap counts down the rest of it.
        src_gap  = $urandom_range(11, 0);
        in_valid <= 1'b0;
      end else begin
        job = pixels_to_send.pop_front();
        in_valid <= 1'b1;
        in_hue   <= job.hue;
        in_sat   <= job.sat;
        in_bri   <= job.bri;
        snk_pct  <= job.snk_pct;
        if (job.stall_sink)
          stall_reqs <= stall_reqs + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sink driver: idle bursts counted down in snk_hold, plus a long hold-off on
  // request so the pipeline fills and backs up into the input.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_seen != stall_reqs) begin
      stall_seen = stall_reqs;
      snk_hold   = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (snk_hold > 0) begin
      snk_hold--;
      out_ready <= 1'b0;
    end else if ($urandom_range(99, 0) < snk_pct) begin
      snk_hold   = $urandom_range(11, 0);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int unsigned pct_tab[3];
    int unsigned src_p;
    int unsigned snk_p;
    bit          drain;
    bit          stall;

    pct_tab = '{0, 15, 40};

    // Directed: sector edges, hue wrap, clamps, gray and the extremes.
    add_pixel(0,     65536,  65536,  0, 0);   // pure red
    add_pixel(1920,  65536,  65536,  0, 0);   // middle of red-yellow
    add_pixel(3839,  65536,  65536,  0, 0);   // last step of sector 0
    add_pixel(3840,  65536,  65536,  0, 0);   // first step of sector 1
    add_pixel(7680,  65536,  65536,  0, 0);   // green-cyan start
    add_pixel(13440, 32768,  65536,  0, 0);   // cyan-blue, half saturation
    add_pixel(15460, 50000,  60000,  0, 0);   // blue-magenta
    add_pixel(22200, 40000,  30000,  0, 0);   // magenta-red
    add_pixel(23039, 65536,  65536,  0, 0);   // just below a full turn
    add_pixel(23040, 65536,  65536,  0, 0);   // full turn wraps to zero
    add_pixel(32767, 40000,  50000,  0, 0);   // top of the hue field wraps
    add_pixel(5000,  0,      65536,  0, 0);   // gray, full brightness
    add_pixel(17000, 0,      12345,  0, 0);   // gray, low brightness
    add_pixel(9000,  131071, 40000,  0, 0);   // saturation clamps
    add_pixel(1234,  65537,  65536,  0, 0);   // just past 1.0 saturation
    add_pixel(17000, 30000,  131071, 0, 0);   // brightness clamps
    add_pixel(11000, 20000,  65537,  0, 0);   // just past 1.0 brightness
    add_pixel(6000,  65536,  0,      0, 0);   // black
    add_pixel(1,     1,      1,      0, 0);   // smallest nonzero values
    add_pixel(21000, 65535,  65535,  0, 0);   // just under 1.0
    add_pixel(21845, 131071, 131071, 0, 0);   // both clamp

    // Random blocks, with the idling mix set by the block index. Some blocks open with a
    // drain pause or a long sink hold-off; the last block runs flat out.
    for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
      for (int i = 0; i < BLOCK_LEN; i++) begin
        src_p = pct_tab[blk % 3];
        snk_p = pct_tab[(blk + blk / 3) % 3];
        drain = (i == 0) && (blk % 4 == 1);
        stall = (i == 0) && (blk % 4 == 2);
        // Keep offering pixels right through the sink hold-off.
        if (blk % 4 == 2 && i < 40)
          src_p = 0;
        if (blk == RAND_BLOCKS - 1) begin
          src_p = 0;
          snk_p = 0;
        end
        add_pixel(rand_hue(), rand_q16(), rand_q16(), src_p, snk_p, drain, stall);
      end
    end
    n_items = pixels_to_send.size();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for every pixel to be taken, then for every prediction to be met,
    // then a few more cycles to catch any stray output.
    while (n_taken < n_items) @(negedge clk);
    while (rgb_due.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (errors == 0) begin
      $display("PASS hsv_to_rgb_converter");
    end else begin
      $display("FAIL hsv_to_rgb_converter");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("FAIL hsv_to_rgb_converter");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/hsv2rgb_pkg.sv
rtl/core/hsv2rgb_ifs.sv
rtl/core/hsv2rgb_decode.sv
rtl/core/hsv2rgb_term.sv
rtl/core/hsv_to_rgb_converter.sv
rtl/core/hsv2rgb_checker.sv
dv/tb_hsv_to_rgb_converter.sv
